// ----- hw/rtl/cover_inequality_lifter_unit_macros.svh -----
// assertion macros for the cover inequality lifter
`ifndef COVER_INEQUALITY_LIFTER_UNIT_MACROS_SVH
`define COVER_INEQUALITY_LIFTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CIL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cover lifter check failed");
`define CIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cover lifter check failed");
`else
`define CIL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/cil_pkg.sv -----
package cil_pkg;

	localparam int DATA_W = 32;
	localparam int SUM_W  = 38;

	typedef struct packed {
		logic coef_wr;
		logic sum_wr;
		logic coef_rd;
		logic sum_rd;
	} cil_mem_ctl_t;

	typedef struct packed {
		logic above_lower;
		logic within_upper;
	} cil_cmp_t;

endpackage

// ----- hw/rtl/cil_row_store.sv -----
module cil_row_store import cil_pkg::*; #(
	parameter int MAX_ELEMS = 32,
	parameter int IDX_W     = 5
) (
	input  logic                    clk,
	input  cil_mem_ctl_t            ctl,
	input  logic [IDX_W-1:0]        coef_idx,
	input  logic [IDX_W-1:0]        sum_idx,
	input  logic signed [DATA_W-1:0] wr_coef,
	input  logic                    wr_cover,
	input  logic signed [SUM_W-1:0] wr_sum,
	output logic signed [DATA_W-1:0] rd_coef,
	output logic                    rd_cover,
	output logic signed [SUM_W-1:0] rd_sum
);

	logic [DATA_W:0]  coef_mem [MAX_ELEMS];
	logic [SUM_W-1:0] sum_mem  [MAX_ELEMS];
	logic [DATA_W:0]  coef_rd_q;
	logic [SUM_W-1:0] sum_rd_q;

	// coefficient with its cover flag, one port
	always_ff @(posedge clk) begin
		if (ctl.coef_wr) begin
			coef_mem[coef_idx] <= {wr_cover, wr_coef};
		end
		if (ctl.coef_rd) begin
			coef_rd_q <= coef_mem[coef_idx];
		end
	end

	// entry k holds the prefix sum over the first k+1 cover elements
	always_ff @(posedge clk) begin
		if (ctl.sum_wr) begin
			sum_mem[sum_idx] <= wr_sum;
		end
		if (ctl.sum_rd) begin
			sum_rd_q <= sum_mem[sum_idx];
		end
	end

	assign rd_coef  = coef_rd_q[DATA_W-1:0];
	assign rd_cover = coef_rd_q[DATA_W];
	assign rd_sum   = sum_rd_q;

endmodule

// ----- hw/rtl/cil_cmp.sv -----
module cil_cmp import cil_pkg::*; (
	input  logic signed [DATA_W-1:0] value,
	input  logic signed [SUM_W-1:0]  lower,
	input  logic signed [SUM_W-1:0]  upper,
	output cil_cmp_t                 result
);

	logic signed [SUM_W-1:0] value_ext;

	assign value_ext           = {{(SUM_W-DATA_W){value[DATA_W-1]}}, value};
	assign result.above_lower  = value_ext > lower;
	assign result.within_upper = value_ext <= upper;

endmodule

// ----- hw/rtl/cover_inequality_lifter_unit.sv -----
// channel  | handshake                 | payload
// item     | item_valid / item_stall   | coefficient, in_cover, last_element
// result   | result_valid / result_stall | lifted_value, is_last
//
// one transaction loads per cycle while not stalled; a row of n elements emits n + 1 results
// a cover element is read and goes straight to output; a non-cover element is compared with the
// prefix sums one at a time via the single-port sum memory and one compare unit until it lands
// at interval h or nowhere; the right-side result comes last; each waits while result_stall holds
// arst_n clears the sequencer and counters; the row memories are not cleared
// item_stall is high once the last element of a row is taken until its right side is taken
`include "cover_inequality_lifter_unit_macros.svh"

module cover_inequality_lifter_unit import cil_pkg::*; #(
	parameter int MAX_ELEMS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic signed [DATA_W-1:0] coefficient,
	input  logic                     in_cover,
	input  logic                     last_element,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [DATA_W-1:0] lifted_value,
	output logic                     is_last
);

	localparam int CNT_W = $clog2(MAX_ELEMS + 1);
	localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ELEM_RD,
		ST_SUM_RD,
		ST_CMP,
		ST_OUT,
		ST_RHS
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        elem_cnt_q;
	logic [CNT_W-1:0]        cov_cnt_q;
	logic [CNT_W-1:0]        elem_idx_q;
	logic [CNT_W-1:0]        h_q;
	logic signed [SUM_W-1:0] run_sum_q;
	logic signed [SUM_W-1:0] prev_q;
	logic signed [DATA_W-1:0] res_q;

	cil_mem_ctl_t            mem_ctl;
	logic [IDX_W-1:0]        coef_idx;
	logic [IDX_W-1:0]        sum_idx;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [DATA_W-1:0] rd_coef;
	logic                    rd_cover;
	logic signed [SUM_W-1:0] rd_sum;
	cil_cmp_t                cmp;
	logic                    accept;
	logic                    room;
	logic                    out_done;

	always_comb begin
		accept          = item_valid && (state_q == ST_LOAD);
		room            = elem_cnt_q < CNT_W'(MAX_ELEMS);
		out_done        = !result_stall;
		mem_ctl.coef_wr = accept && room;
		mem_ctl.sum_wr  = accept && room && in_cover;
		mem_ctl.coef_rd = (state_q == ST_ELEM_RD);
		mem_ctl.sum_rd  = (state_q == ST_SUM_RD);
		coef_idx        = (state_q == ST_LOAD) ? elem_cnt_q[IDX_W-1:0] : elem_idx_q[IDX_W-1:0];
		sum_idx         = (state_q == ST_LOAD) ? cov_cnt_q[IDX_W-1:0] : h_q[IDX_W-1:0];
		sum_next        = run_sum_q + {{(SUM_W-DATA_W){coefficient[DATA_W-1]}}, coefficient};
	end

	cil_row_store #(
		.MAX_ELEMS(MAX_ELEMS),
		.IDX_W    (IDX_W)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.coef_idx(coef_idx),
		.sum_idx (sum_idx),
		.wr_coef (coefficient),
		.wr_cover(in_cover),
		.wr_sum  (sum_next),
		.rd_coef (rd_coef),
		.rd_cover(rd_cover),
		.rd_sum  (rd_sum)
	);

	cil_cmp u_cmp (
		.value (rd_coef),
		.lower (prev_q),
		.upper (rd_sum),
		.result(cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			elem_cnt_q <= '0;
			cov_cnt_q  <= '0;
			elem_idx_q <= '0;
			h_q        <= '0;
			run_sum_q  <= '0;
			prev_q     <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							elem_cnt_q <= elem_cnt_q + 1'b1;
							if (in_cover) begin
								cov_cnt_q <= cov_cnt_q + 1'b1;
								run_sum_q <= sum_next;
							end
						end
						if (last_element) begin
							elem_idx_q <= '0;
							state_q    <= ST_ELEM_RD;
						end
					end
				end
				ST_ELEM_RD: begin
					h_q     <= '0;
					prev_q  <= '0;
					state_q <= ST_SUM_RD;
				end
				ST_SUM_RD: begin
					if (rd_cover) begin
						res_q   <= DATA_W'(1);
						state_q <= ST_OUT;
					end else if (h_q == cov_cnt_q) begin
						res_q   <= rd_coef;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (cmp.above_lower && cmp.within_upper) begin
						res_q   <= {{(DATA_W-CNT_W){1'b0}}, h_q};
						state_q <= ST_OUT;
					end else begin
						prev_q  <= rd_sum;
						h_q     <= h_q + 1'b1;
						state_q <= ST_SUM_RD;
					end
				end
				ST_OUT: begin
					if (out_done) begin
						if (CNT_W'(elem_idx_q + 1'b1) == elem_cnt_q) begin
							res_q   <= {{(DATA_W-CNT_W){1'b0}}, cov_cnt_q} - DATA_W'(1);
							state_q <= ST_RHS;
						end else begin
							elem_idx_q <= elem_idx_q + 1'b1;
							state_q    <= ST_ELEM_RD;
						end
					end
				end
				ST_RHS: begin
					if (out_done) begin
						elem_cnt_q <= '0;
						cov_cnt_q  <= '0;
						run_sum_q  <= '0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != ST_LOAD);
	assign result_valid = (state_q == ST_OUT) || (state_q == ST_RHS);
	assign is_last      = (state_q == ST_RHS);
	assign lifted_value = res_q;

	`CIL_ASSERT_SAME(a_cov_le_elem, clk, arst_n, 1'b1, cov_cnt_q <= elem_cnt_q)
	`CIL_ASSERT_SAME(a_elem_bound, clk, arst_n, 1'b1, elem_cnt_q <= CNT_W'(MAX_ELEMS))
	`CIL_ASSERT_SAME(a_scan_bound, clk, arst_n, state_q == ST_CMP, h_q < cov_cnt_q)
	`CIL_ASSERT_NEXT(a_row_restart, clk, arst_n, result_valid && !result_stall && is_last,
		state_q == ST_LOAD && elem_cnt_q == '0 && cov_cnt_q == '0)

endmodule
